// File: design/arpc_pkg.sv
`timescale 1ns / 1ps
package arpc_pkg;
    localparam int unsigned CacheEntriesDef = 32;
    localparam logic [4:0] LifeReloadRst = 5'd20;
    localparam logic [4:0] RefreshLevelRst = 5'd10;

    localparam logic [2:0] REQ_RESOLVE = 3'd0;
    localparam logic [2:0] REQ_ADD = 3'd1;
    localparam logic [2:0] REQ_UPDATE = 3'd2;
    localparam logic [2:0] REQ_DELETE = 3'd3;
    localparam logic [2:0] REQ_AGE = 3'd4;
    localparam logic [2:0] REQ_CLEAR = 3'd5;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic CFG_LIFE_RELOAD = 1'b0;
    localparam logic CFG_REFRESH_LEVEL = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_AGE
    } t_state;

    // command to every cell, decided from the lookup
    typedef struct packed {
        logic        wr;        // write the addressed cell
        logic        inv;       // invalidate the addressed cell
        logic        clr;       // invalidate all cells
        logic        set_ip;
        logic        set_dyn;
        logic        dyn;
        logic [47:0] mac;
        logic        stable;
        logic [4:0]  life;
    } t_cell_cmd;

    // one entry as it travels through the aging ring
    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [4:0]  life;
        logic        dyn;
        logic        stable;
    } t_entry;
endpackage

// File: design/arp_cache_with_aging.sv
`timescale 1ns / 1ps
// ARP cache: IPv4 to MAC, fully associative, one cell per entry.
// Requests enter on i_start while o_busy is low; config writes use
// i_cfg_valid/o_cfg_ready (always ready) with i_cfg_index and i_cfg_data.
// Every result is shown for one cycle with o_valid; o_last marks the final
// result of a request. The receiver cannot stall the block.
// Resolve, add, update, delete, clear and unknown requests: the match
// compare runs in the cycle after the transfer and the single result
// appears in the cycle after that, when a new request can be taken.
// Aging tick: the entries rotate once around the ring of cells, entry 0
// first, one entry per cycle; the block stays busy for the rotation and a
// closing step, and the last result is registered in that closing step.
// Each refresh request is held one step behind its entry so that the final
// one can carry o_last; at most one result per cycle.
// Reset invalidates all entries and loads life_reload 20, refresh_level 10.
module arp_cache_with_aging
    import arpc_pkg::*;
#(
    parameter int unsigned CACHE_ENTRIES = CacheEntriesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_ip_addr,
    input  logic [47:0] i_mac_addr,
    input  logic        i_dynamic_entry,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [47:0] o_mac_out,
    output logic        o_send_request,
    output logic [31:0] o_request_ip,
    output logic        o_last
);
    localparam int unsigned IW = $clog2(CACHE_ENTRIES);
    localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);

    t_state r_state, n_state;
    logic [4:0] r_life_reload, r_refresh;
    logic [2:0] r_req;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic r_dyn;
    logic [CW-1:0] r_cnt;
    logic r_any;
    logic [31:0] r_pend;

    logic r_ov, r_ol, r_osr;
    logic [1:0] r_ost;
    logic [47:0] r_omac;
    logic [31:0] r_oip;

    t_entry w_e [CACHE_ENTRIES];
    t_entry w_prev [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] w_hit, w_sel;
    logic w_shift;
    t_cell_cmd w_cmd;
    t_entry w_aged;

    // first hit and first free entry
    logic w_hf, w_ff;
    logic [IW-1:0] w_hi, w_fi;
    always_comb begin
        w_hf = 1'b0;
        w_ff = 1'b0;
        w_hi = '0;
        w_fi = '0;
        for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                w_hf = 1'b1;
                w_hi = IW'(k);
            end
            if (!w_e[k].valid) begin
                w_ff = 1'b1;
                w_fi = IW'(k);
            end
        end
    end

    // the entry leaving the ring head, aged
    logic w_emit;
    always_comb begin
        w_aged = w_e[0];
        w_emit = 1'b0;
        if (w_aged.valid) begin
            if (w_aged.life == 5'd0) begin
                w_aged.valid = 1'b0;
            end else if (w_aged.life <= r_refresh) begin
                w_emit = 1'b1;
                w_aged.life = w_aged.life - 5'd1;
            end else if (w_aged.dyn) begin
                w_aged.life = w_aged.life - 5'd1;
            end
        end
    end

    assign w_shift = (r_state == S_AGE) && (r_cnt != '0);

    logic w_age_out;
    assign w_age_out = (r_state == S_AGE) && ((r_cnt == '0) || (w_emit && r_any));

    genvar g;
    generate
        for (g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
            if (g == CACHE_ENTRIES - 1) begin : g_head
                assign w_prev[g] = w_aged;
            end else begin : g_body
                assign w_prev[g] = w_e[g+1];
            end
            arpc_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(w_shift),
                .i_prev (w_prev[g]),
                .i_sel  (w_sel[g]),
                .i_cmd  (w_cmd),
                .i_ip   (r_ip),
                .o_entry(w_e[g]),
                .o_hit  (w_hit[g])
            );
        end
    endgenerate

    // decode the request against the lookup
    logic [IW-1:0] w_idx;
    logic w_rv, w_rs;
    logic [1:0] w_rst;
    logic [47:0] w_rmac;
    logic [31:0] w_rip;
    always_comb begin
        w_cmd = '0;
        w_idx = w_hi;
        w_rs = 1'b0;
        w_rst = ST_DONE;
        w_rmac = '0;
        w_rip = '0;
        w_rv = (r_state == S_LOOKUP);
        w_cmd.mac = r_mac;
        w_cmd.life = r_life_reload;
        w_cmd.stable = 1'b1;
        w_cmd.dyn = r_dyn;
        unique case (r_req)
            REQ_RESOLVE: begin
                if (w_hf) begin
                    if (w_e[w_hi].stable) begin
                        w_rmac = w_e[w_hi].mac;
                    end else begin
                        w_rst = ST_PENDING;
                        w_rs = 1'b1;
                        w_rip = r_ip;
                    end
                end else if (w_ff) begin
                    w_idx = w_fi;
                    w_cmd.wr = 1'b1;
                    w_cmd.set_ip = 1'b1;
                    w_cmd.set_dyn = 1'b1;
                    w_cmd.dyn = 1'b1;
                    w_cmd.mac = '0;
                    w_cmd.stable = 1'b0;
                    w_cmd.life = r_refresh;
                    w_rst = ST_PENDING;
                    w_rs = 1'b1;
                    w_rip = r_ip;
                end else begin
                    w_rst = ST_FULL;
                end
            end
            REQ_ADD: begin
                if (w_hf) begin
                    w_cmd.wr = 1'b1;
                    w_cmd.set_dyn = 1'b1;
                end else if (w_ff) begin
                    w_idx = w_fi;
                    w_cmd.wr = 1'b1;
                    w_cmd.set_dyn = 1'b1;
                    w_cmd.set_ip = 1'b1;
                end else begin
                    w_rst = ST_FULL;
                end
            end
            REQ_UPDATE: begin
                if (w_hf && w_e[w_hi].dyn) w_cmd.wr = 1'b1;
                else w_rst = ST_NOMATCH;
            end
            REQ_DELETE: begin
                if (w_hf) w_cmd.inv = 1'b1;
                else w_rst = ST_NOMATCH;
            end
            REQ_CLEAR: w_cmd.clr = 1'b1;
            default: w_rst = ST_NOMATCH;
        endcase
        if (r_state != S_LOOKUP) w_cmd = '0;
    end

    always_comb begin
        w_sel = '0;
        w_sel[w_idx] = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = (i_req_type == REQ_AGE) ? S_AGE : S_LOOKUP;
            S_LOOKUP: n_state = S_IDLE;
            S_AGE: if (r_cnt == '0) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != S_IDLE);
        o_cfg_ready = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_life_reload <= LifeReloadRst;
            r_refresh <= RefreshLevelRst;
            r_req <= REQ_RESOLVE;
            r_ov <= 1'b0;
            r_cnt <= '0;
            r_any <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LIFE_RELOAD: r_life_reload <= i_cfg_data;
                    CFG_REFRESH_LEVEL: r_refresh <= i_cfg_data;
                    default: ;
                endcase
            end
            r_ov <= w_rv || w_age_out;
            if (r_state == S_IDLE && i_start) begin
                r_req <= i_req_type;
                r_ip <= i_ip_addr;
                r_mac <= i_mac_addr;
                r_dyn <= i_dynamic_entry;
                r_cnt <= CW'(CACHE_ENTRIES);
                r_any <= 1'b0;
            end
            if (w_rv) begin
                r_ol <= 1'b1;
                r_ost <= w_rst;
                r_omac <= w_rmac;
                r_osr <= w_rs;
                r_oip <= w_rip;
            end
            if (r_state == S_AGE) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                    if (w_emit) begin
                        // hold the request until the next one or the end shows last
                        r_any <= 1'b1;
                        r_pend <= w_aged.ip;
                        if (r_any) begin
                            r_ol <= 1'b0;
                            r_ost <= ST_PENDING;
                            r_omac <= '0;
                            r_osr <= 1'b1;
                            r_oip <= r_pend;
                        end
                    end
                end else begin
                    r_ol <= 1'b1;
                    r_omac <= '0;
                    r_ost <= r_any ? ST_PENDING : ST_DONE;
                    r_osr <= r_any;
                    r_oip <= r_any ? r_pend : '0;
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_mac_out = r_omac;
    assign o_send_request = r_osr;
    assign o_request_ip = r_oip;
    assign o_last = r_ol;
endmodule

// File: design/arpc_cell.sv
`timescale 1ns / 1ps
module arpc_cell
    import arpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_shift,
    input  t_entry      i_prev,
    input  logic        i_sel,
    input  t_cell_cmd   i_cmd,
    input  logic [31:0] i_ip,
    output t_entry      o_entry,
    output logic        o_hit
);
    t_entry r_e;

    assign o_entry = r_e;
    assign o_hit = r_e.valid && (r_e.ip == i_ip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else if (i_shift) begin
            r_e <= i_prev;
        end else if (i_cmd.clr) begin
            r_e.valid <= 1'b0;
        end else if (i_sel) begin
            if (i_cmd.inv) begin
                r_e.valid <= 1'b0;
            end else if (i_cmd.wr) begin
                r_e.valid <= 1'b1;
                if (i_cmd.set_ip) r_e.ip <= i_ip;
                if (i_cmd.set_dyn) r_e.dyn <= i_cmd.dyn;
                r_e.mac <= i_cmd.mac;
                r_e.stable <= i_cmd.stable;
                r_e.life <= i_cmd.life;
            end
        end
    end
endmodule
